// File: rtl/h2wfc_pkg.sv
// Shared types, codes and arithmetic helpers of the HTTP/2 window flow control block.
package h2wfc_pkg;

  // Field widths
  localparam int MODE_W   = 4;
  localparam int STREAM_W = 4;
  localparam int WIN_W    = 31;
  localparam int CONN_W   = 40;
  localparam int DELTA_W  = 36;

  // Event kinds
  localparam logic [MODE_W-1:0] MODE_SENT      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_RECV      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_POLL_CONN = 4'd2;
  localparam logic [MODE_W-1:0] MODE_POLL_STRM = 4'd3;
  localparam logic [MODE_W-1:0] MODE_CONN_UPD  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_STRM_UPD  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_READ_HINT = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DESTROY   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_URGENCY   = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CONN_OVF  = 2'd1;
  localparam logic [1:0] ST_STRM_OVF  = 2'd2;
  localparam logic [1:0] ST_TOLERATED = 2'd3;

  // Urgency codes
  localparam logic [1:0] URG_NONE  = 2'd0;
  localparam logic [1:0] URG_NOW   = 2'd1;
  localparam logic [1:0] URG_QUEUE = 2'd2;

  // Register indexes
  localparam logic REG_SENT_INIT  = 1'b0;
  localparam logic REG_ACKED_INIT = 1'b1;

  // Window constants
  localparam logic [WIN_W-1:0] MAX_WIN     = 31'h7FFF_FFFF;
  localparam logic [31:0]      U32_ALL     = 32'hFFFF_FFFF;
  localparam logic [WIN_W-1:0] INIT_WINDOW = 31'd65535;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [STREAM_W-1:0] stream;
    logic                stream_valid;
    logic [WIN_W-1:0]    amount;
    logic [31:0]         max_hint;
    logic [31:0]         unread_bytes;
    logic                out_pending;
    logic                rx_closed;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] announce;
    logic [1:0]  conn_urgency;
    logic [1:0]  stream_urgency;
  } result_t;

  typedef struct packed {
    logic [WIN_W-1:0] sent;
    logic [WIN_W-1:0] acked;
  } cfg_t;

  typedef struct packed {
    logic signed [CONN_W-1:0] peer;
    logic signed [CONN_W-1:0] lca;
    logic signed [CONN_W-1:0] over;
    logic signed [CONN_W-1:0] under;
  } conn_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] peer;
    logic signed [DELTA_W-1:0] local_d;
    logic signed [DELTA_W-1:0] announced;
  } row_t;

  // Clamp a two-bit-wider sum to the connection window range
  function automatic logic signed [CONN_W-1:0] sat40(input logic signed [CONN_W+1:0] v);
    logic signed [CONN_W-1:0] r;
    r = v[CONN_W-1:0];
    if (v[CONN_W+1:CONN_W-1] != 3'b000 && v[CONN_W+1:CONN_W-1] != 3'b111) begin
      r = v[CONN_W+1] ? {1'b1, {(CONN_W-1){1'b0}}} : {1'b0, {(CONN_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp a two-bit-wider sum to the stream delta range
  function automatic logic signed [DELTA_W-1:0] sat36(input logic signed [DELTA_W+1:0] v);
    logic signed [DELTA_W-1:0] r;
    r = v[DELTA_W-1:0];
    if (v[DELTA_W+1:DELTA_W-1] != 3'b000 && v[DELTA_W+1:DELTA_W-1] != 3'b111) begin
      r = v[DELTA_W+1] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/h2wfc_regs.sv
// APB configuration registers: initial stream windows sent and acknowledged.
module h2wfc_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output h2wfc_pkg::cfg_t      cfg,
  output h2wfc_pkg::cfg_t      cfg_next
);
  import h2wfc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the word address; byte offset bits are ignored
  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SENT_INIT:  cfg_next.sent  = pwdata[WIN_W-1:0];
        REG_ACKED_INIT: cfg_next.acked = pwdata[WIN_W-1:0];
        default:        cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sent  <= INIT_WINDOW;
      cfg.acked <= INIT_WINDOW;
    end else begin
      cfg <= cfg_next;
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_SENT_INIT:  prdata = {1'b0, cfg.sent};
      REG_ACKED_INIT: prdata = {1'b0, cfg.acked};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/h2wfc_table.sv
// Per-stream table of peer, local and announced window deltas.
module h2wfc_table #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IW-1:0]       addr,
  input  logic                we,
  input  h2wfc_pkg::row_t     wdata,
  output h2wfc_pkg::row_t     rdata
);
  import h2wfc_pkg::*;

  row_t rows [DEPTH];

  // Clear every slot at reset, then write one slot per event
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        rows[i] <= '0;
      end
    end else if (we) begin
      rows[addr] <= wdata;
    end
  end

  assign rdata = rows[addr];

endmodule

// File: rtl/h2wfc_event.sv
// Event datapath: next connection state, next slot row and the result of one event.
module h2wfc_event (
  input  h2wfc_pkg::item_t    item,
  input  logic                sv,
  input  h2wfc_pkg::row_t     row,
  input  h2wfc_pkg::conn_t    conn,
  input  h2wfc_pkg::cfg_t     cfg,
  input  logic [30:0]         target,
  input  logic [30:0]         thr_half,
  input  logic [30:0]         thr_3q,
  output h2wfc_pkg::conn_t    conn_next,
  output h2wfc_pkg::row_t     row_next,
  output logic                row_we,
  output h2wfc_pkg::result_t  res
);
  import h2wfc_pkg::*;

  logic signed [CONN_W+1:0]  amt42, lca42, peer42, t42, thr42, cdiff, over42, under42;
  logic signed [CONN_W+1:0]  pos_old, pos_new, neg_old, neg_new;
  logic signed [DELTA_W+1:0] amt38, ad38, ld38, spd38, lim_acked, lim_sent, sdiff;
  logic signed [DELTA_W+1:0] sent38, half38, want38;
  logic signed [DELTA_W-1:0] ad_recv, ld_recv, ad_poll, new_ad;
  logic signed [CONN_W-1:0]  lca_recv, lca_poll;
  logic                      conn_ovf, ack_ovf, snt_ovf, grant_ok, cclamp, sclamp, tot_we;
  logic [31:0]               cap, want0, want;

  // Sign- or zero-extend operands to the working widths
  assign amt42   = {11'd0, item.amount};
  assign lca42   = {{2{conn.lca[CONN_W-1]}}, conn.lca};
  assign peer42  = {{2{conn.peer[CONN_W-1]}}, conn.peer};
  assign over42  = {{2{conn.over[CONN_W-1]}}, conn.over};
  assign under42 = {{2{conn.under[CONN_W-1]}}, conn.under};
  assign t42     = {11'd0, target};
  assign thr42   = {11'd0, (item.out_pending ? thr_3q : thr_half)};
  assign amt38   = {7'd0, item.amount};
  assign ad38    = {{2{row.announced[DELTA_W-1]}}, row.announced};
  assign ld38    = {{2{row.local_d[DELTA_W-1]}}, row.local_d};
  assign spd38   = {{2{row.peer[DELTA_W-1]}}, row.peer};
  assign sent38  = {7'd0, cfg.sent};
  assign half38  = {8'd0, cfg.sent[WIN_W-1:1]};

  // Received data checks
  assign conn_ovf  = amt42 > lca42;
  assign lim_acked = ad38 + {7'd0, cfg.acked};
  assign lim_sent  = ad38 + sent38;
  assign ack_ovf   = amt38 > lim_acked;
  assign snt_ovf   = amt38 > lim_sent;
  assign ad_recv   = sat36(ad38 - amt38);
  assign ld_recv   = sat36(ld38 - amt38);
  assign lca_recv  = sat40(lca42 - amt42);

  // Connection grant: top the announced window up to the target
  assign grant_ok = (lca42 <= thr42) && (lca42 != t42);
  assign cdiff    = t42 - lca42;
  assign cclamp   = cdiff > {10'd0, U32_ALL};
  assign lca_poll = cclamp ? sat40(lca42 + {10'd0, U32_ALL}) : {9'd0, target};

  // Stream grant: announce what the local delta is ahead by
  assign sdiff   = ld38 - ad38;
  assign sclamp  = sdiff > {6'd0, U32_ALL};
  assign ad_poll = sclamp ? sat36(ad38 + {6'd0, U32_ALL}) : row.local_d;

  // Read hint: bytes wanted beyond what is already buffered
  assign cap    = U32_ALL - {1'b0, cfg.sent};
  assign want0  = (item.max_hint >= cap) ? cap : item.max_hint;
  assign want   = (want0 >= item.unread_bytes) ? (want0 - item.unread_bytes) : 32'd0;
  assign want38 = {6'd0, want};

  // Totals follow the sign of the old and new announced delta
  assign pos_old = (row.announced > 0) ? {{4{ad38[DELTA_W+1]}}, ad38} : '0;
  assign neg_old = (row.announced > 0) ? '0 : {{4{ad38[DELTA_W+1]}}, ad38};

  always_comb begin
    conn_next = conn;
    row_next  = row;
    row_we    = 1'b0;
    res       = '0;
    new_ad    = row.announced;
    tot_we    = 1'b0;
    case (item.mode)
      MODE_SENT: begin
        conn_next.peer = sat40(peer42 - amt42);
        if (sv) begin
          row_next.peer = sat36(spd38 - amt38);
          row_we        = 1'b1;
        end
      end
      MODE_RECV: begin
        if (conn_ovf) begin
          res.status = ST_CONN_OVF;
        end else if (sv && ack_ovf && snt_ovf) begin
          res.status = ST_STRM_OVF;
        end else begin
          if (sv) begin
            if (ack_ovf) begin
              res.status = ST_TOLERATED;
            end
            row_next.announced = ad_recv;
            row_next.local_d   = ld_recv;
            row_we             = 1'b1;
            new_ad             = ad_recv;
            tot_we             = 1'b1;
          end
          conn_next.lca = lca_recv;
        end
      end
      MODE_POLL_CONN: begin
        if (grant_ok) begin
          res.announce  = cclamp ? U32_ALL : cdiff[31:0];
          conn_next.lca = lca_poll;
        end
      end
      MODE_POLL_STRM: begin
        if (sv && (row.local_d > row.announced)) begin
          res.announce       = sclamp ? U32_ALL : sdiff[31:0];
          row_next.announced = ad_poll;
          row_we             = 1'b1;
          new_ad             = ad_poll;
          tot_we             = 1'b1;
        end
      end
      MODE_CONN_UPD: begin
        conn_next.peer = sat40(peer42 + amt42);
      end
      MODE_STRM_UPD: begin
        if (sv) begin
          row_next.peer = sat36(spd38 + amt38);
          row_we        = 1'b1;
        end
      end
      MODE_READ_HINT: begin
        if (sv && (ld38 < want38)) begin
          row_next.local_d = {4'd0, want};
          row_we           = 1'b1;
        end
      end
      MODE_DESTROY: begin
        if (sv) begin
          row_next = '0;
          row_we   = 1'b1;
          new_ad   = '0;
          tot_we   = 1'b1;
        end
      end
      MODE_URGENCY: begin
        if (lca42 < {11'd0, thr_half}) begin
          res.conn_urgency = URG_NOW;
        end
        if (sv && !item.rx_closed && (row.local_d > row.announced)) begin
          res.stream_urgency = (lim_sent <= half38) ? URG_NOW : URG_QUEUE;
        end
      end
      default: begin
        res = '0;
      end
    endcase
    // Move the slot's announced delta between the totals
    pos_new = (new_ad > 0) ? {{6{new_ad[DELTA_W-1]}}, new_ad} : '0;
    neg_new = (new_ad > 0) ? '0 : {{6{new_ad[DELTA_W-1]}}, new_ad};
    if (tot_we) begin
      conn_next.over  = sat40(over42 - pos_old + pos_new);
      conn_next.under = sat40(under42 - neg_old + neg_new);
    end
  end

endmodule

// File: rtl/http2_window_flow_control_top.sv
// HTTP/2 window flow control: top level with stream ports, connection state and APB port.
//
// Tracks the connection credit windows and per-stream window deltas of one HTTP/2
// connection and answers each event (data sent or received, update polls, peer
// updates, read hints, stream destroy, urgency query) with one result. An event is
// captured in an input register, evaluated against the connection registers and one
// slot of the stream table, and its result is held in an output register. One event
// is accepted per cycle while results are taken; a result left waiting holds the input.
// Back-to-back events see each other's updates because the table slot and the
// connection registers are written in the same cycle the result is captured. Only the
// first min(STREAMS, 16) slots exist; a slot number at or above STREAMS acts on the
// connection alone. The table is cleared directly at reset.
module http2_window_flow_control_top #(
  parameter int STREAMS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // stream request in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // stream[3:0], stream_valid, amount[30:0], max_hint[31:0],
                                 // unread_bytes[31:0], out_pending, rx_closed, zero pad
  input  logic [3:0]   s_tuser,  // mode[3:0]
  // result out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,  // status[1:0], announce[31:0], conn_urgency[1:0],
                                 // stream_urgency[1:0], zero pad
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import h2wfc_pkg::*;

  localparam int DEPTH = (STREAMS < (2 ** STREAM_W)) ? STREAMS : (2 ** STREAM_W);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [30:0] INIT_HALF = INIT_WINDOW >> 1;
  localparam logic [30:0] INIT_3Q   = 31'((33'(INIT_WINDOW) * 33'd3) >> 2);

  item_t       in_item, s_item;
  logic        in_full, fire, sv;
  result_t     res, out_res;
  logic        out_full;
  cfg_t        cfg, cfg_next;
  conn_t       conn, conn_next, conn_d;
  row_t        row, row_next;
  logic        row_we;
  logic [30:0] target, thr_half, thr_3q, target_next;
  logic signed [CONN_W+1:0] tsum;
  logic [32:0] t3;

  // Unpack the request
  assign s_item.mode         = s_tuser;
  assign s_item.stream       = s_tdata[3:0];
  assign s_item.stream_valid = s_tdata[4];
  assign s_item.amount       = s_tdata[35:5];
  assign s_item.max_hint     = s_tdata[67:36];
  assign s_item.unread_bytes = s_tdata[99:68];
  assign s_item.out_pending  = s_tdata[100];
  assign s_item.rx_closed    = s_tdata[101];

  // Advance when the held request can place its result
  assign fire     = in_full && (!out_full || m_tready);
  assign s_tready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  assign sv = in_item.stream_valid && (32'(in_item.stream) < 32'(STREAMS));

  h2wfc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cfg_next (cfg_next)
  );

  h2wfc_table #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .addr  (in_item.stream[IW-1:0]),
    .we    (fire && row_we),
    .wdata (row_next),
    .rdata (row)
  );

  h2wfc_event u_event (
    .item      (in_item),
    .sv        (sv),
    .row       (row),
    .conn      (conn),
    .cfg       (cfg),
    .target    (target),
    .thr_half  (thr_half),
    .thr_3q    (thr_3q),
    .conn_next (conn_next),
    .row_next  (row_next),
    .row_we    (row_we),
    .res       (res)
  );

  // Hold connection state; update it on each evaluated event
  assign conn_d = fire ? conn_next : conn;

  always_ff @(posedge clk) begin
    if (rst) begin
      conn.peer  <= {9'd0, INIT_WINDOW};
      conn.lca   <= {9'd0, INIT_WINDOW};
      conn.over  <= '0;
      conn.under <= '0;
    end else begin
      conn <= conn_d;
    end
  end

  // Keep the target window and its thresholds ready for the next event
  assign tsum        = {{2{conn_d.over[CONN_W-1]}}, conn_d.over} + {11'd0, cfg_next.sent};
  assign target_next = (tsum > {11'd0, MAX_WIN}) ? MAX_WIN :
                       (tsum < 0) ? 31'd0 : tsum[30:0];
  assign t3          = {2'b00, target_next} + {1'b0, target_next, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= INIT_WINDOW;
      thr_half <= INIT_HALF;
      thr_3q   <= INIT_3Q;
    end else begin
      target   <= target_next;
      thr_half <= target_next >> 1;
      thr_3q   <= t3[32:2];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {2'b00, out_res.stream_urgency, out_res.conn_urgency,
                     out_res.announce, out_res.status};

  // Positive announced deltas only ever feed the over-initial total
  a_over_nonneg: assert property (@(posedge clk) disable iff (rst) !conn.over[CONN_W-1])
    else $error("total over initial went negative");

  // Non-positive announced deltas only ever feed the under-initial total
  a_under_nonpos: assert property (@(posedge clk) disable iff (rst) conn.under <= 0)
    else $error("total under initial went positive");

  // Thresholds stay ordered below the target
  a_thr_order: assert property (@(posedge clk) disable iff (rst)
    (thr_half <= thr_3q) && (thr_3q <= target))
    else $error("window thresholds out of order");

  // A refused connection frame leaves the announced window alone
  a_refused: assert property (@(posedge clk) disable iff (rst)
    fire && (in_item.mode == MODE_RECV) && (res.status == ST_CONN_OVF) |=> $stable(conn.lca))
    else $error("refused frame changed the connection window");

  // An evaluated event always leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (rst) fire |=> out_full)
    else $error("evaluated event produced no result");

endmodule

// File: sim/tb_http2_window_flow_control_top.sv
// Testbench for the HTTP/2 window flow control block: directed table, then random phases.
`timescale 1ns / 1ps

module tb_http2_window_flow_control_top;
  import h2wfc_pkg::*;

  localparam longint WIN_CAP = 64'sd2147483647;
  localparam longint ALL32 = 64'sd4294967295;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 4'd9;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 4'd15;
  localparam result_t QUIET = '0;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 270;

  typedef struct {
    bit      is_cfg;
    logic    reg_sel;
    longint  cfg_val;
    item_t   ev;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;  // stream[3:0], stream_valid, amount[30:0], max_hint[31:0],
                               // unread_bytes[31:0], out_pending, rx_closed, zero pad
  logic [3:0]   s_tuser = '0;  // mode[3:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;       // status[1:0], announce[31:0], conn_urgency[1:0],
                               // stream_urgency[1:0], zero pad
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  http2_window_flow_control_top #(.STREAMS(16)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Window state mirrored from the block
  longint cfg_sent = 65535;
  longint cfg_acked = 65535;
  longint conn_peer = 65535;
  longint conn_lca = 65535;
  longint over_sum = 0;
  longint under_sum = 0;
  longint row_peer [16];
  longint row_local [16];
  longint row_ann [16];

  result_t replies_due [$];
  int errors = 0;
  int replies_seen = 0;
  bit calm = 1'b0;
  result_t got, due;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t reply %0d: %s", $time, replies_seen, msg);
    errors++;
  endtask

  function automatic longint clamp_to(input longint v, input int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic longint window_goal();
    longint t;
    t = over_sum + cfg_sent;
    if (t > WIN_CAP) t = WIN_CAP;
    if (t < 0) t = 0;
    return t;
  endfunction

  function automatic void retire_total(input longint ad);
    if (ad > 0) over_sum = clamp_to(over_sum - ad, CONN_W);
    else under_sum = clamp_to(under_sum - ad, CONN_W);
  endfunction

  function automatic void move_announced(input int s, input longint v);
    retire_total(row_ann[s]);
    row_ann[s] = clamp_to(v, DELTA_W);
    if (row_ann[s] > 0) over_sum = clamp_to(over_sum + row_ann[s], CONN_W);
    else under_sum = clamp_to(under_sum + row_ann[s], CONN_W);
  endfunction

  // Apply one request to the mirrored windows and work out its reply
  function automatic void advance_windows(input item_t ev, output result_t res);
    longint amt, hint, have, t, thr, grant, ad, ld, cap, want;
    int s;
    bit on_stream;
    res = '0;
    grant = 0;
    amt = {33'd0, ev.amount};
    hint = {32'd0, ev.max_hint};
    have = {32'd0, ev.unread_bytes};
    on_stream = ev.stream_valid;
    s = on_stream ? int'(ev.stream) : 0;
    case (ev.mode)
      MODE_SENT: begin
        conn_peer = clamp_to(conn_peer - amt, CONN_W);
        if (on_stream) row_peer[s] = clamp_to(row_peer[s] - amt, DELTA_W);
      end
      MODE_RECV: begin
        if (amt > conn_lca) begin
          res.status = ST_CONN_OVF;
        end else begin
          ad = row_ann[s];
          if (on_stream && amt > ad + cfg_acked) begin
            res.status = (amt <= ad + cfg_sent) ? ST_TOLERATED : ST_STRM_OVF;
          end
          // Refused frames leave every window alone
          if (res.status != ST_STRM_OVF) begin
            if (on_stream) begin
              move_announced(s, ad - amt);
              row_local[s] = clamp_to(row_local[s] - amt, DELTA_W);
            end
            conn_lca = clamp_to(conn_lca - amt, CONN_W);
          end
        end
      end
      MODE_POLL_CONN: begin
        t = window_goal();
        thr = ev.out_pending ? (3 * t) / 4 : t / 2;
        if (conn_lca <= thr && conn_lca != t) begin
          grant = t - conn_lca;
          if (grant < 0) grant = 0;
          if (grant > ALL32) grant = ALL32;
          conn_lca = clamp_to(conn_lca + grant, CONN_W);
        end
      end
      MODE_POLL_STRM: begin
        if (on_stream && row_local[s] > row_ann[s]) begin
          grant = row_local[s] - row_ann[s];
          if (grant > ALL32) grant = ALL32;
          move_announced(s, row_ann[s] + grant);
        end
      end
      MODE_CONN_UPD: conn_peer = clamp_to(conn_peer + amt, CONN_W);
      MODE_STRM_UPD: begin
        if (on_stream) row_peer[s] = clamp_to(row_peer[s] + amt, DELTA_W);
      end
      MODE_READ_HINT: begin
        if (on_stream) begin
          cap = ALL32 - cfg_sent;
          want = (hint >= cap) ? cap : hint;
          want = (want >= have) ? want - have : 0;
          if (row_local[s] < want) row_local[s] = want;
        end
      end
      MODE_DESTROY: begin
        if (on_stream) begin
          retire_total(row_ann[s]);
          row_peer[s] = 0;
          row_local[s] = 0;
          row_ann[s] = 0;
        end
      end
      MODE_URGENCY: begin
        if (conn_lca < window_goal() / 2) res.conn_urgency = URG_NOW;
        if (on_stream && !ev.rx_closed) begin
          ld = row_local[s];
          ad = row_ann[s];
          if (ld > ad) begin
            res.stream_urgency = (ad + cfg_sent <= cfg_sent / 2) ? URG_NOW : URG_QUEUE;
          end
        end
      end
      default: ;
    endcase
    res.announce = grant[31:0];
  endfunction

  // Hand one request to the block, then log its expected reply
  task automatic offer_request(input item_t ev, input bit typed, input result_t want);
    result_t predicted;
    if (!calm && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ev.mode;
    s_tdata <= {2'b00, ev.rx_closed, ev.out_pending, ev.unread_bytes, ev.max_hint,
                ev.amount, ev.stream_valid, ev.stream};
    do @(posedge clk); while (!s_tready);
    advance_windows(ev, predicted);
    replies_due.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every reply is back
  task automatic settle_windows();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_window_reg(input logic which, input longint value);
    settle_windows();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= {1'b0, value[30:0]};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_SENT_INIT) cfg_sent = value & WIN_CAP;
    else cfg_acked = value & WIN_CAP;
  endtask

  function automatic stim_row_t ev_row(input logic [3:0] mode, input logic [3:0] stream,
                                       input bit sv, input longint amount,
                                       input longint hint, input longint have,
                                       input bit pend, input bit rc,
                                       input bit typed, input result_t want);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = REG_SENT_INIT;
    r.cfg_val = 0;
    r.ev = '{mode, stream, sv, amount[30:0], hint[31:0], have[31:0], pend, rc};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic which, input longint value);
    stim_row_t r;
    r = ev_row(MODE_SENT, 0, 0, 0, 0, 0, 0, 0, 0, QUIET);
    r.is_cfg = 1'b1;
    r.reg_sel = which;
    r.cfg_val = value;
    return r;
  endfunction

  // Random request, leaning toward busy slots and window-sized frames
  function automatic item_t random_request();
    item_t ev;
    int unsigned pick, v;
    pick = $urandom_range(0, 99);
    if (pick < 4) ev.mode = MODE_W'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
    else if (pick < 24) ev.mode = MODE_RECV;
    else if (pick < 36) ev.mode = MODE_POLL_CONN;
    else if (pick < 52) ev.mode = MODE_POLL_STRM;
    else if (pick < 66) ev.mode = MODE_READ_HINT;
    else if (pick < 78) ev.mode = MODE_URGENCY;
    else if (pick < 86) ev.mode = MODE_SENT;
    else if (pick < 91) ev.mode = MODE_CONN_UPD;
    else if (pick < 95) ev.mode = MODE_STRM_UPD;
    else ev.mode = MODE_DESTROY;
    ev.stream = STREAM_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 15));
    ev.stream_valid = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: ev.amount = WIN_W'($urandom_range(0, 4000));
      5, 6: begin
        v = $urandom_range(0, int'(cfg_sent) + 2000);
        ev.amount = (v > WIN_CAP) ? MAX_WIN : v[30:0];
      end
      7: ev.amount = WIN_W'($urandom);
      8: ev.amount = '0;
      default: ev.amount = MAX_WIN;
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 5) ev.max_hint = $urandom_range(0, 200000);
    else if (pick < 8) ev.max_hint = $urandom;
    else ev.max_hint = (pick == 8) ? 32'd0 : U32_ALL;
    pick = $urandom_range(0, 9);
    if (pick < 6) ev.unread_bytes = $urandom_range(0, 50000);
    else if (pick < 9) ev.unread_bytes = $urandom;
    else ev.unread_bytes = U32_ALL;
    ev.out_pending = 1'($urandom_range(0, 1));
    ev.rx_closed = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Take replies with random back-pressure and check each against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[1:0], m_tdata[33:2], m_tdata[35:34], m_tdata[37:36]};
        if (replies_due.size() == 0) begin
          flag_error("reply with no request outstanding");
        end else begin
          due = replies_due.pop_front();
          if (got.status != due.status)
            flag_error($sformatf("status %0d, want %0d", got.status, due.status));
          if (got.announce != due.announce)
            flag_error($sformatf("announce %0d, want %0d", got.announce, due.announce));
          if (got.conn_urgency != due.conn_urgency)
            flag_error($sformatf("conn_urgency %0d, want %0d",
                                 got.conn_urgency, due.conn_urgency));
          if (got.stream_urgency != due.stream_urgency)
            flag_error($sformatf("stream_urgency %0d, want %0d",
                                 got.stream_urgency, due.stream_urgency));
        end
        replies_seen++;
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  initial begin
    stim_row_t script [$];
    longint phase_sent [PHASES];
    longint phase_acked [PHASES];
    for (int i = 0; i < 16; i++) begin
      row_peer[i] = 0;
      row_local[i] = 0;
      row_ann[i] = 0;
    end

    // Directed rows: reset values, extremes, every event kind and the odd cases
    script.push_back(ev_row(MODE_URGENCY, 0, 0, 0, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_RECV, 0, 0, 65536, 0, 0, 0, 0, 1,
                            '{ST_CONN_OVF, 32'd0, URG_NONE, URG_NONE}));
    script.push_back(ev_row(MODE_RECV, 0, 1, 65535, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_POLL_CONN, 0, 0, 0, 0, 0, 0, 0, 1,
                            '{ST_OK, 32'd65535, URG_NONE, URG_NONE}));
    script.push_back(ev_row(MODE_URGENCY, 0, 1, 0, 0, 0, 0, 0, 0, QUIET));
    script.push_back(ev_row(MODE_READ_HINT, 0, 1, 0, ALL32, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_URGENCY, 0, 1, 0, 0, 0, 0, 0, 1,
                            '{ST_OK, 32'd0, URG_NONE, URG_NOW}));
    script.push_back(ev_row(MODE_POLL_STRM, 0, 1, 0, 0, 0, 0, 0, 1,
                            '{ST_OK, U32_ALL, URG_NONE, URG_NONE}));
    script.push_back(ev_row(MODE_POLL_CONN, 0, 0, 0, 0, 0, 1, 0, 0, QUIET));
    script.push_back(ev_row(MODE_SENT, 3, 1, WIN_CAP, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_CONN_UPD, 0, 0, WIN_CAP, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_STRM_UPD, 15, 1, WIN_CAP, ALL32, ALL32, 1, 1, 1, QUIET));
    script.push_back(ev_row(MODE_READ_HINT, 2, 1, 0, 1000, ALL32, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_URGENCY, 2, 1, 0, 0, 0, 0, 1, 0, QUIET));
    script.push_back(ev_row(MODE_DESTROY, 0, 1, 0, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_DESTROY, 1, 0, 0, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_POLL_STRM, 5, 0, 0, 0, 0, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_UNKNOWN_LO, 4, 1, 1000, 5, 5, 0, 0, 1, QUIET));
    script.push_back(ev_row(MODE_UNKNOWN_HI, 15, 1, WIN_CAP, ALL32, ALL32, 1, 1, 1, QUIET));
    // Sent window above the acked one opens the tolerated band
    script.push_back(cfg_row(REG_SENT_INIT, 100000));
    script.push_back(cfg_row(REG_ACKED_INIT, 65535));
    script.push_back(ev_row(MODE_RECV, 5, 1, 80000, 0, 0, 0, 0, 0, QUIET));
    script.push_back(ev_row(MODE_RECV, 6, 1, 200000, 0, 0, 0, 0, 0, QUIET));
    script.push_back(ev_row(MODE_URGENCY, 5, 1, 0, 0, 0, 0, 0, 0, QUIET));
    script.push_back(ev_row(MODE_URGENCY, 7, 0, 0, 0, 0, 1, 0, 0, QUIET));

    phase_sent = '{65535, 0, WIN_CAP, 100000, 65535, 0, 16};
    phase_acked = '{65535, 0, WIN_CAP, 65535, 100000, 0, WIN_CAP};
    phase_sent[5] = $urandom & WIN_CAP;
    phase_acked[5] = $urandom_range(0, 200000);

    // Hold reset, then release
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_window_reg(script[i].reg_sel, script[i].cfg_val);
      else offer_request(script[i].ev, script[i].typed, script[i].want);
    end

    // Random phases, each under its own window settings
    for (int p = 0; p < PHASES; p++) begin
      write_window_reg(REG_SENT_INIT, phase_sent[p]);
      write_window_reg(REG_ACKED_INIT, phase_acked[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) offer_request(random_request(), 1'b0, QUIET);
      calm = 1'b0;
    end

    settle_windows();
    if (errors == 0 && replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/h2wfc_pkg.sv
rtl/h2wfc_regs.sv
rtl/h2wfc_table.sv
rtl/h2wfc_event.sv
rtl/http2_window_flow_control_top.sv
sim/tb_http2_window_flow_control_top.sv
